### rtl/lvs_pkg.sv
// ----------------------------------------------------------------------------
// lvs_pkg
// Shared constants, codes and types of the LRU victim selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lvs_pkg;

	// Frame count and derived widths
	localparam int NUM_FRAMES = 64;
	localparam int FRAME_W    = 6;
	localparam int LINK_W     = $clog2(NUM_FRAMES + 1);
	localparam int OPCODE_W   = 2;

	// Link value that names the list head (sentinel entry)
	localparam logic [LINK_W-1:0] SENTINEL = LINK_W'(NUM_FRAMES);

	// Operation codes
	typedef enum logic [OPCODE_W-1:0] {
		OP_UNPIN  = 2'd0,
		OP_PIN    = 2'd1,
		OP_VICTIM = 2'd2
	} op_t;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Link RAM write request
	typedef struct packed {
		logic               en;
		logic [FRAME_W-1:0] addr;
		logic [LINK_W-1:0]  data;
	} ram_wr_t;

	// Link RAM read request (both RAMs read the same entry)
	typedef struct packed {
		logic               en;
		logic [FRAME_W-1:0] addr;
	} ram_rd_t;

	// One result beat
	typedef struct packed {
		logic               accepted;
		logic [FRAME_W-1:0] victim_frame;
		logic [LINK_W-1:0]  evictable_count;
	} result_t;

endpackage

`default_nettype wire

### rtl/lvs_chan_if.sv
// ----------------------------------------------------------------------------
// lvs_cmd_if / lvs_rsp_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface lvs_cmd_if;
	import lvs_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [FRAME_W-1:0]  frame_num;

	modport source (output valid, output opcode, output frame_num, input ready);
	modport sink   (input valid, input opcode, input frame_num, output ready);
endinterface

interface lvs_rsp_if;
	import lvs_pkg::*;

	logic               valid;
	logic               ready;
	logic               accepted;
	logic [FRAME_W-1:0] victim_frame;
	logic [LINK_W-1:0]  evictable_count;

	modport source (output valid, output accepted, output victim_frame,
		output evictable_count, input ready);
	modport sink   (input valid, input accepted, input victim_frame,
		input evictable_count, output ready);
endinterface

`default_nettype wire

### rtl/lvs_link_ram.sv
// ----------------------------------------------------------------------------
// lvs_link_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lvs_link_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 7,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output      logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/lvs_list_ctrl.sv
// ----------------------------------------------------------------------------
// lvs_list_ctrl
// List sequencer: takes a command beat, reads the target's links, then
// relinks neighbors and updates head, tail, tracked bits and the count.
// ----------------------------------------------------------------------------
`default_nettype none

module lvs_list_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	input  wire logic [lvs_pkg::OPCODE_W-1:0]  cmd_opcode,
	input  wire logic [lvs_pkg::FRAME_W-1:0]   cmd_frame_num,
	output      logic                          cmd_ready,
	input  wire logic                          out_free,
	output      logic                          done,
	output      lvs_pkg::result_t              res,
	output      lvs_pkg::ram_rd_t              rd_req,
	input  wire logic [lvs_pkg::LINK_W-1:0]    rd_next,
	input  wire logic [lvs_pkg::LINK_W-1:0]    rd_prev,
	output      lvs_pkg::ram_wr_t              wr_next,
	output      lvs_pkg::ram_wr_t              wr_prev
);
	import lvs_pkg::*;

	state_t                  state_q, state_n;
	logic [OPCODE_W-1:0]     op_s1;
	logic [FRAME_W-1:0]      fid_s1;
	logic [LINK_W-1:0]       head_q, head_n;
	logic [LINK_W-1:0]       tail_q, tail_n;
	logic [LINK_W-1:0]       count_q, count_n;
	logic [NUM_FRAMES-1:0]   tracked_q, tracked_n;
	logic                    cmd_fire;

	assign cmd_fire = cmd_valid && cmd_ready;

	// Read the target's links as the command is taken
	always_comb begin
		rd_req.en   = cmd_fire;
		rd_req.addr = (cmd_opcode == OP_VICTIM) ? tail_q[FRAME_W-1:0] : cmd_frame_num;
	end

	// Next state, list update and result
	always_comb begin
		logic [FRAME_W-1:0] tgt;
		logic [LINK_W-1:0]  tgt_l;
		logic [LINK_W-1:0]  p;
		logic [LINK_W-1:0]  n;
		logic               hit;

		state_n   = state_q;
		head_n    = head_q;
		tail_n    = tail_q;
		count_n   = count_q;
		tracked_n = tracked_q;
		cmd_ready = (state_q == ST_IDLE);
		done      = 1'b0;
		wr_next   = '0;
		wr_prev   = '0;
		res       = '0;

		tgt   = (op_s1 == OP_VICTIM) ? tail_q[FRAME_W-1:0] : fid_s1;
		tgt_l = {1'b0, tgt};
		// Head has no predecessor and tail no successor but the sentinel
		p     = (tgt_l == head_q) ? SENTINEL : rd_prev;
		n     = (tgt_l == tail_q) ? SENTINEL : rd_next;
		hit   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_n = ST_IDLE;
					done    = 1'b1;
					case (op_s1)
						OP_UNPIN: begin
							hit = !tracked_q[fid_s1];
							if (hit) begin
								// Link in at the most-recent end
								wr_next.en   = 1'b1;
								wr_next.addr = fid_s1;
								wr_next.data = head_q;
								if (head_q == SENTINEL) begin
									tail_n = {1'b0, fid_s1};
								end else begin
									wr_prev.en   = 1'b1;
									wr_prev.addr = head_q[FRAME_W-1:0];
									wr_prev.data = {1'b0, fid_s1};
								end
								head_n            = {1'b0, fid_s1};
								tracked_n[fid_s1] = 1'b1;
								count_n           = count_q + 1'b1;
							end
						end
						OP_PIN, OP_VICTIM: begin
							hit = (op_s1 == OP_PIN) ? tracked_q[fid_s1] : (count_q != '0);
							if (hit) begin
								// Splice the target out of the list
								if (p == SENTINEL) begin
									head_n = n;
								end else begin
									wr_next.en   = 1'b1;
									wr_next.addr = p[FRAME_W-1:0];
									wr_next.data = n;
								end
								if (n == SENTINEL) begin
									tail_n = p;
								end else begin
									wr_prev.en   = 1'b1;
									wr_prev.addr = n[FRAME_W-1:0];
									wr_prev.data = p;
								end
								tracked_n[tgt] = 1'b0;
								count_n        = count_q - 1'b1;
								if (op_s1 == OP_VICTIM) begin
									res.victim_frame = tgt;
								end
							end
						end
						default: begin
							hit = 1'b0;
						end
					endcase
					res.accepted        = hit;
					res.evictable_count = count_n;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= SENTINEL;
			tail_q    <= SENTINEL;
			count_q   <= '0;
			tracked_q <= '0;
		end else begin
			state_q   <= state_n;
			head_q    <= head_n;
			tail_q    <= tail_n;
			count_q   <= count_n;
			tracked_q <= tracked_n;
		end
	end

	// Hold the command for the execute cycle
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_s1  <= cmd_opcode;
			fid_s1 <= cmd_frame_num;
		end
	end

endmodule

`default_nettype wire

### rtl/lru_victim_selector_core.sv
// ----------------------------------------------------------------------------
// lru_victim_selector_core
// LRU replacement tracker for a buffer pool of 64 frames. Evictable frames
// sit in a doubly linked list whose next and prev links live in two 64-entry
// RAMs; the list head, tail, per-frame tracked bits and the count are held
// in flip-flops. Unpin adds an untracked frame at the most-recent end, pin
// drops a tracked frame, victim removes and returns the least-recent frame.
// Each command is accepted in the idle state, where the target's links are
// read from the registered read port of the link RAMs, and completed in
// the execute state, which writes the neighbors' links back. No command is
// accepted while one is executing. Results pass through an output register,
// so a new command is taken while a result waits; the execute cycle holds
// until that register frees. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_victim_selector_core (
	input wire logic clk,
	input wire logic arst_n,
	lvs_cmd_if.sink   cmd,
	lvs_rsp_if.source rsp
);
	import lvs_pkg::*;

	ram_rd_t             rd_req;
	ram_wr_t             wr_next;
	ram_wr_t             wr_prev;
	logic [LINK_W-1:0]   rd_next;
	logic [LINK_W-1:0]   rd_prev;
	logic                done;
	logic                out_free;
	result_t             res;
	logic                out_valid_q;
	result_t             out_q;

	assign out_free = !out_valid_q || rsp.ready;

	lvs_list_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd.valid),
		.cmd_opcode    (cmd.opcode),
		.cmd_frame_num (cmd.frame_num),
		.cmd_ready     (cmd.ready),
		.out_free      (out_free),
		.done          (done),
		.res           (res),
		.rd_req        (rd_req),
		.rd_next       (rd_next),
		.rd_prev       (rd_prev),
		.wr_next       (wr_next),
		.wr_prev       (wr_prev)
	);

	lvs_link_ram #(.DEPTH(NUM_FRAMES), .WIDTH(LINK_W)) u_next_ram (
		.clk     (clk),
		.wr_en   (wr_next.en),
		.wr_addr (wr_next.addr),
		.wr_data (wr_next.data),
		.rd_en   (rd_req.en),
		.rd_addr (rd_req.addr),
		.rd_data (rd_next)
	);

	lvs_link_ram #(.DEPTH(NUM_FRAMES), .WIDTH(LINK_W)) u_prev_ram (
		.clk     (clk),
		.wr_en   (wr_prev.en),
		.wr_addr (wr_prev.addr),
		.wr_data (wr_prev.data),
		.rd_en   (rd_req.en),
		.rd_addr (rd_req.addr),
		.rd_data (rd_prev)
	);

	// Result beat valid: set on completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.accepted        = out_q.accepted;
	assign rsp.victim_frame    = out_q.victim_frame;
	assign rsp.evictable_count = out_q.evictable_count;

endmodule

`default_nettype wire

### rtl/lvs_checker.sv
// ----------------------------------------------------------------------------
// lvs_checker
// Port-level checks of the LRU victim selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lvs_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cmd_valid,
	input wire logic                         cmd_ready,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_ready,
	input wire logic                         rsp_accepted,
	input wire logic [lvs_pkg::FRAME_W-1:0]  rsp_victim_frame,
	input wire logic [lvs_pkg::LINK_W-1:0]   rsp_evictable_count
);
	import lvs_pkg::*;

	// Count never exceeds the frame count
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_evictable_count <= LINK_W'(NUM_FRAMES)))
		else $error("evictable_count out of range");

	// A rejected command reports no victim frame
	a_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_accepted) |-> (rsp_victim_frame == '0))
		else $error("victim_frame set on a rejected beat");

	// One command in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted back to back");

	// A stalled result beat holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_accepted)
			&& $stable(rsp_victim_frame) && $stable(rsp_evictable_count)))
		else $error("result beat changed while stalled");

endmodule

bind lru_victim_selector_core lvs_checker u_lvs_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cmd_valid           (cmd.valid),
	.cmd_ready           (cmd.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_accepted        (rsp.accepted),
	.rsp_victim_frame    (rsp.victim_frame),
	.rsp_evictable_count (rsp.evictable_count)
);

`default_nettype wire
